[design/sva_pkg.sv]
// ----------------------------------------------------------------------------
// sva_pkg
// Shared widths, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package sva_pkg;

   localparam int CordicStepsDefault = 24;
   localparam int FracBitsDefault    = 7;

   // Normalisation loop bound and CORDIC datapath width
   localparam int NormSteps = 32;
   localparam int CordW     = 96;

   typedef logic signed [15:0] comp_type;

   typedef struct packed {
      comp_type a_x;
      comp_type a_y;
      comp_type a_z;
      comp_type b_x;
      comp_type b_y;
      comp_type b_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] angle;
      logic               degenerate;
   } rsp_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;  5'd31: r = 32'h00000000;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

[design/sva_if.sv]
// ----------------------------------------------------------------------------
// sva_req_if / sva_rsp_if
// Valid/ready channels carrying request and response transactions.
// ----------------------------------------------------------------------------
interface sva_req_if;
   logic              valid;
   logic              ready;
   sva_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface sva_rsp_if;
   logic              valid;
   logic              ready;
   sva_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[design/sva_front.sv]
// ----------------------------------------------------------------------------
// sva_front
// Products, cross and dot sums, and the squared cross length. Four stages.
// ----------------------------------------------------------------------------
module sva_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  sva_pkg::req_type    in_data,
   output logic                out_valid,
   output logic [63:0]         out_s,
   output logic signed [34:0]  out_d,
   output logic                out_neg,
   output logic                out_degen
);
   // stage 1: the nine component products
   logic                v1_ff;
   logic signed [31:0]  p_ff [9];
   logic                z1_ff;
   // stage 2: cross and dot
   logic                v2_ff, z2_ff;
   logic signed [32:0]  cx_ff, cy_ff, cz_ff;
   logic signed [34:0]  d2_ff;
   // stage 3: squares
   logic                v3_ff, z3_ff, n3_ff;
   logic [65:0]         q_ff [3];
   logic signed [34:0]  d3_ff;
   // stage 4: sum
   logic                v4_ff, z4_ff, n4_ff;
   logic [63:0]         s4_ff;
   logic signed [34:0]  d4_ff;

   logic signed [32:0]  ax_in, ay_in, az_in;
   logic                a0, b0;

   assign a0 = (in_data.a_x == 16'sd0) && (in_data.a_y == 16'sd0) && (in_data.a_z == 16'sd0);
   assign b0 = (in_data.b_x == 16'sd0) && (in_data.b_y == 16'sd0) && (in_data.b_z == 16'sd0);
   assign ax_in = 33'(p_ff[0]) - 33'(p_ff[1]);
   assign ay_in = 33'(p_ff[2]) - 33'(p_ff[3]);
   assign az_in = 33'(p_ff[4]) - 33'(p_ff[5]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff[0] <= in_data.a_y * in_data.b_z;
         p_ff[1] <= in_data.a_z * in_data.b_y;
         p_ff[2] <= in_data.a_z * in_data.b_x;
         p_ff[3] <= in_data.a_x * in_data.b_z;
         p_ff[4] <= in_data.a_x * in_data.b_y;
         p_ff[5] <= in_data.a_y * in_data.b_x;
         p_ff[6] <= in_data.a_x * in_data.b_x;
         p_ff[7] <= in_data.a_y * in_data.b_y;
         p_ff[8] <= in_data.a_z * in_data.b_z;
         z1_ff   <= a0 | b0;
         cx_ff   <= ax_in; cy_ff <= ay_in; cz_ff <= az_in;
         d2_ff   <= 35'(p_ff[6]) + 35'(p_ff[7]) + 35'(p_ff[8]);
         z2_ff   <= z1_ff;
         q_ff[0] <= 66'(cx_ff * cx_ff);
         q_ff[1] <= 66'(cy_ff * cy_ff);
         q_ff[2] <= 66'(cz_ff * cz_ff);
         n3_ff   <= cz_ff[32];
         d3_ff   <= d2_ff; z3_ff <= z2_ff;
         s4_ff   <= 64'(q_ff[0] + q_ff[1] + q_ff[2]);
         n4_ff   <= n3_ff; d4_ff <= d3_ff; z4_ff <= z3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_s     = s4_ff;
   assign out_d     = d4_ff;
   assign out_neg   = n4_ff;
   assign out_degen = z4_ff;
endmodule

[design/sva_sqrt.sv]
// ----------------------------------------------------------------------------
// sva_sqrt
// Normalisation by priority shift, then a pipelined integer square root,
// one result bit per stage.
// ----------------------------------------------------------------------------
module sva_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [63:0]         in_s,
   input  logic signed [34:0]  in_d,
   input  logic                in_neg,
   input  logic                in_degen,
   output logic                out_valid,
   output logic [31:0]         out_l,
   output logic signed [66:0]  out_d,
   output logic                out_neg,
   output logic                out_degen
);
   localparam int NS = 32;

   // Shift count: smallest e with s*4^e >= 2^60 or |d*2^e| >= 2^30, cap 32.
   logic [5:0]  es_in, ed_in, e_in;
   logic [34:0] dabs;
   logic        nv_ff, nn_ff, nz_ff;
   logic [5:0]  ne_ff;
   logic [63:0] ns_ff;
   logic signed [34:0] nd_ff;

   always_comb begin
      es_in = 6'd32;
      for (int k = 31; k >= 0; k--) begin
         if ((64'(in_s) << (2 * k)) >= 64'h1000_0000_0000_0000 &&
             (in_s >> (64 - 2 * k)) == 64'd0 || (k == 0 && in_s >= 64'h1000_0000_0000_0000))
            es_in = 6'(k);
      end
      dabs  = in_d[34] ? 35'(-in_d) : 35'(in_d);
      ed_in = 6'd32;
      for (int k = 31; k >= 0; k--) begin
         if ((36'(dabs) << k) >= 36'h4000_0000 || (k == 0 && dabs >= 35'h4000_0000))
            ed_in = 6'(k);
      end
      e_in = (es_in < ed_in) ? es_in : ed_in;
   end

   // Square root stages
   logic        v_ff [NS+1];
   logic [63:0] r_ff [NS+1];
   logic [63:0] q_ff [NS+1];
   logic [31:0] y_ff [NS+1];
   logic signed [66:0] d_ff [NS+1];
   logic        n_ff [NS+1];
   logic        z_ff [NS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= 1'b0;
         for (int k = 0; k <= NS; k++) v_ff[k] <= 1'b0;
      end else if (adv) begin
         nv_ff   <= in_valid;
         v_ff[0] <= nv_ff;
         for (int k = 1; k <= NS; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ne_ff <= e_in; ns_ff <= in_s; nd_ff <= in_d; nn_ff <= in_neg; nz_ff <= in_degen;
         r_ff[0] <= 64'd0;
         q_ff[0] <= (ne_ff == 6'd32) ? 64'd0 : (ns_ff << (2 * ne_ff));
         y_ff[0] <= 32'd0;
         d_ff[0] <= 67'(nd_ff) <<< ne_ff;
         n_ff[0] <= nn_ff; z_ff[0] <= nz_ff;
         for (int k = 1; k <= NS; k++) begin
            if ((r_ff[k-1][61:0] << 2 | 64'(q_ff[k-1][63:62])) >= 64'({y_ff[k-1], 2'b01})) begin
               r_ff[k] <= (r_ff[k-1] << 2 | 64'(q_ff[k-1][63:62])) - 64'({y_ff[k-1], 2'b01});
               y_ff[k] <= {y_ff[k-1][30:0], 1'b1};
            end else begin
               r_ff[k] <= r_ff[k-1] << 2 | 64'(q_ff[k-1][63:62]);
               y_ff[k] <= {y_ff[k-1][30:0], 1'b0};
            end
            q_ff[k] <= q_ff[k-1] << 2;
            d_ff[k] <= d_ff[k-1]; n_ff[k] <= n_ff[k-1]; z_ff[k] <= z_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[NS];
   assign out_l     = y_ff[NS];
   assign out_d     = d_ff[NS];
   assign out_neg   = n_ff[NS];
   assign out_degen = z_ff[NS];
endmodule

[design/sva_cordic.sv]
// ----------------------------------------------------------------------------
// sva_cordic
// Vectoring CORDIC, one rotation per stage, then clamp, scale and sign.
// ----------------------------------------------------------------------------
module sva_cordic #(
   parameter int CORDIC_STEPS = sva_pkg::CordicStepsDefault,
   parameter int FRAC_BITS    = sva_pkg::FracBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [31:0]         in_l,
   input  logic signed [66:0]  in_d,
   input  logic                in_neg,
   input  logic                in_degen,
   output logic                out_valid,
   output sva_pkg::rsp_type    out_data
);
   localparam int W  = sva_pkg::CordW;
   localparam int NC = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
   localparam logic [63:0] Scale = 64'(360) << FRAC_BITS;
   localparam logic signed [31:0] Ninety = 32'(90) << FRAC_BITS;

   logic                v_ff [NC+1];
   logic signed [W-1:0] x_ff [NC+1];
   logic signed [W-1:0] y_ff [NC+1];
   logic signed [35:0]  z_ff [NC+1];
   logic                n_ff [NC+1];
   logic                g_ff [NC+1];

   logic signed [W-1:0] l_w;
   assign l_w = W'($signed({1'b0, in_l}));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NC; k++) v_ff[k] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k <= NC; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   // >>> on a signed value floors, as the rotation needs
   always_ff @(posedge clock) begin
      if (adv) begin
         if (!in_d[66]) begin
            x_ff[0] <= W'(in_d) <<< 28; y_ff[0] <= l_w <<< 28; z_ff[0] <= 36'sd0;
         end else begin
            x_ff[0] <= l_w <<< 28; y_ff[0] <= (-W'(in_d)) <<< 28;
            z_ff[0] <= 36'sh4000_0000;
         end
         n_ff[0] <= in_neg; g_ff[0] <= in_degen;
         for (int k = 1; k <= NC; k++) begin
            if (!y_ff[k-1][W-1]) begin
               x_ff[k] <= x_ff[k-1] + (y_ff[k-1] >>> (k-1));
               y_ff[k] <= y_ff[k-1] - (x_ff[k-1] >>> (k-1));
               z_ff[k] <= z_ff[k-1] + 36'($signed({1'b0, sva_pkg::atan_entry(5'(k-1))}));
            end else begin
               x_ff[k] <= x_ff[k-1] - (y_ff[k-1] >>> (k-1));
               y_ff[k] <= y_ff[k-1] + (x_ff[k-1] >>> (k-1));
               z_ff[k] <= z_ff[k-1] - 36'($signed({1'b0, sva_pkg::atan_entry(5'(k-1))}));
            end
            n_ff[k] <= n_ff[k-1]; g_ff[k] <= g_ff[k-1];
         end
      end
   end

   // Clamp stage, then scale, sign and saturate stage
   logic        c_v_ff, c_n_ff, c_g_ff, o_v_ff;
   logic [31:0] c_z_ff;
   logic [31:0] c_z_in;
   logic [95:0] prod;
   logic signed [48:0] mag, res;
   sva_pkg::rsp_type o_ff, o_in;

   always_comb begin
      if (z_ff[NC] < 0) c_z_in = 32'd0;
      else if (z_ff[NC] > 36'sh8000_0000) c_z_in = 32'h8000_0000;
      else c_z_in = 32'(z_ff[NC]);
      prod = 96'(c_z_ff) * 96'(Scale) + 96'h8000_0000;
      mag  = 49'(prod >> 32);
      res  = c_n_ff ? -mag : mag;
      o_in.degenerate = c_g_ff;
      if (c_g_ff) o_in.angle = (Ninety > 32767) ? 16'sh7FFF : 16'(Ninety);
      else if (res > 49'sd32767) o_in.angle = 16'sh7FFF;
      else if (res < -49'sd32768) o_in.angle = 16'sh8000;
      else o_in.angle = 16'(res);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0; o_v_ff <= 1'b0;
      end else if (adv) begin
         c_v_ff <= v_ff[NC]; o_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_z_ff <= c_z_in; c_n_ff <= n_ff[NC]; c_g_ff <= g_ff[NC];
         o_ff   <= o_in;
      end
   end

   assign out_valid = o_v_ff;
   assign out_data  = o_ff;
endmodule

[design/signed_vector_angle_core.sv]
// ----------------------------------------------------------------------------
// signed_vector_angle_core
// Signed angle between two 3D integer vectors, fully pipelined.
// ----------------------------------------------------------------------------
// One transaction enters every cycle while the response side does not
// stall. The stages are, in order: products and sums, the normalisation
// (shift count, then shift), the square root, one stage per CORDIC
// rotation plus a load stage, and clamp, scaling and sign. The whole pipe
// advances when the output register is empty or being taken, so a stall
// on the response side holds every stage; nothing is dropped or repeated.
// The angle is in 2^-FRAC_BITS degree; a zero vector gives +90 degrees with
// degenerate set.
module signed_vector_angle_core #(
   parameter int CORDIC_STEPS = sva_pkg::CordicStepsDefault,
   parameter int FRAC_BITS    = sva_pkg::FracBitsDefault
) (
   input  logic      clock,
   input  logic      reset,
   sva_req_if.sink   req,
   sva_rsp_if.source rsp
);
   logic adv;
   logic f_v, f_n, f_g, q_v, q_n, q_g;
   logic [63:0] f_s;
   logic signed [34:0] f_d;
   logic [31:0] q_l;
   logic signed [66:0] q_d;

   // Advance while the final register is free or drained this cycle
   assign adv       = ~rsp.valid | rsp.ready;
   assign req.ready = adv;

   sva_front u_front (
      .clock, .reset, .adv,
      .in_valid(req.valid), .in_data(req.data),
      .out_valid(f_v), .out_s(f_s), .out_d(f_d), .out_neg(f_n), .out_degen(f_g)
   );

   sva_sqrt u_sqrt (
      .clock, .reset, .adv,
      .in_valid(f_v), .in_s(f_s), .in_d(f_d), .in_neg(f_n), .in_degen(f_g),
      .out_valid(q_v), .out_l(q_l), .out_d(q_d), .out_neg(q_n), .out_degen(q_g)
   );

   sva_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cordic (
      .clock, .reset, .adv,
      .in_valid(q_v), .in_l(q_l), .in_d(q_d), .in_neg(q_n), .in_degen(q_g),
      .out_valid(rsp.valid), .out_data(rsp.data)
   );

   // Hold the response while it stalls
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("response changed under stall");
   a_deg: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.degenerate |-> rsp.data.angle >= 0)
      else $error("degenerate angle negative");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("input stalled with empty output");
endmodule

[dv/signed_vector_angle_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_vector_angle_core_tb
// Streams vector pairs through the angle core and checks every response
// transaction against an in-bench CORDIC predictor, under random idling,
// a long response stall and a full drain pause.
// ----------------------------------------------------------------------------
module signed_vector_angle_core_tb;

   localparam int Steps       = sva_pkg::CordicStepsDefault;
   localparam int Frac        = sva_pkg::FracBitsDefault;
   localparam int StallLimit  = 5000;   // cycles with no transaction at all
   localparam int DrainCycles = 100;    // pipeline is 65 deep at the defaults
   localparam int RandomItems = 930;

   // Arctangent of 2^-i as a binary angle, 2^32 per turn
   localparam logic [31:0] ArcTab [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000};

   class angle_scoreboard;
      sva_pkg::rsp_type pending_angles[$];
      int      mismatches;
      int      orphans;

      // Integer square root, floor, bit by bit
      function automatic longint unsigned floor_sqrt(longint unsigned s);
         longint unsigned root, bit_w;
         root  = 0;
         bit_w = 64'd1 << 62;
         while (bit_w > s) bit_w >>= 2;
         while (bit_w != 0) begin
            if (s >= root + bit_w) begin
               s    = s - (root + bit_w);
               root = (root >> 1) + bit_w;
            end else begin
               root >>= 1;
            end
            bit_w >>= 2;
         end
         return root;
      endfunction

      function automatic sva_pkg::rsp_type predict_angle(sva_pkg::req_type t);
         longint ax, ay, az, bx, by, bz, cx, cy, cz, dot, x, y, xn, yn, z, res;
         longint unsigned sq, mag;
         sva_pkg::rsp_type r;
         ax = t.a_x; ay = t.a_y; az = t.a_z;
         bx = t.b_x; by = t.b_y; bz = t.b_z;
         if ((ax == 0 && ay == 0 && az == 0) || (bx == 0 && by == 0 && bz == 0)) begin
            res = 90 << Frac;
            if (res > 32767) res = 32767;
            r.angle      = res[15:0];
            r.degenerate = 1'b1;
            return r;
         end
         cx  = ay * bz - az * by;
         cy  = az * bx - ax * bz;
         cz  = ax * by - ay * bx;
         dot = ax * bx + ay * by + az * bz;
         sq  = longint'(cx * cx) + longint'(cy * cy) + longint'(cz * cz);
         // Normalise: scale the pair up until either side is large
         for (int e = 0; e < 32; e++) begin
            if (!(sq < (64'd1 << 60) && dot < (64'sd1 << 30) && dot > -(64'sd1 << 30)))
               break;
            sq  = sq << 2;
            dot = dot * 2;
         end
         if (dot >= 0) begin
            x = dot;
            y = longint'(floor_sqrt(sq));
            z = 0;
         end else begin
            x = longint'(floor_sqrt(sq));
            y = -dot;
            z = 64'sd1 << 30;
         end
         x = x <<< 28;
         y = y <<< 28;
         for (int i = 0; i < Steps && i < 32; i++) begin
            if (y >= 0) begin
               xn = x + (y >>> i);
               yn = y - (x >>> i);
               z  = z + longint'(ArcTab[i]);
            end else begin
               xn = x - (y >>> i);
               yn = y + (x >>> i);
               z  = z - longint'(ArcTab[i]);
            end
            x = xn;
            y = yn;
         end
         if (z < 0) z = 0;
         if (z > (64'sd1 << 31)) z = 64'sd1 << 31;
         mag = (longint'(z) * (64'd360 << Frac) + (64'd1 << 31)) >> 32;
         res = longint'(mag);
         if (cz < 0) res = -res;
         if (res > 32767) res = 32767;
         if (res < -32768) res = -32768;
         r.angle      = res[15:0];
         r.degenerate = 1'b0;
         return r;
      endfunction

      function void note_request(sva_pkg::req_type t);
         pending_angles.push_back(predict_angle(t));
      endfunction

      function void check_response(sva_pkg::rsp_type got);
         sva_pkg::rsp_type exp_r;
         if (pending_angles.size() == 0) begin
            orphans++;
            if (mismatches + orphans <= 10)
               $display("unexpected response: angle %0d degenerate %0b",
                        got.angle, got.degenerate);
            return;
         end
         exp_r = pending_angles.pop_front();
         if (got.angle !== exp_r.angle || got.degenerate !== exp_r.degenerate) begin
            mismatches++;
            if (mismatches + orphans <= 10)
               $display("mismatch: angle exp %0d got %0d, degenerate exp %0b got %0b",
                        exp_r.angle, got.angle, exp_r.degenerate, got.degenerate);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   sva_req_if req_ch ();
   sva_rsp_if rsp_ch ();

   signed_vector_angle_core DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   angle_scoreboard board = new();

   int send_idle_pct;
   int recv_idle_pct;
   int hold_request;     // bump to start a long response stall
   int hold_len;
   int quiet_cycles;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end

   // Response side: random back-pressure, plus a long hold on request
   always @(posedge clock) begin : rsp_sink
      int seen_hold;
      int hold_left;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_request != seen_hold) begin
         seen_hold = hold_request;
         hold_left = hold_len;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check every response transaction and watch for a hung pipe
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_response(rsp_ch.data);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Offer one transaction, idling first at random; hold valid until taken
   task automatic send_vectors(input sva_pkg::req_type t);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= t;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(t);
   endtask

   task automatic send_pair(input int ax, ay, az, bx, by, bz);
      sva_pkg::req_type t;
      t.a_x = ax[15:0]; t.a_y = ay[15:0]; t.a_z = az[15:0];
      t.b_x = bx[15:0]; t.b_y = by[15:0]; t.b_z = bz[15:0];
      send_vectors(t);
   endtask

   function automatic sva_pkg::comp_type pick_comp(int mode);
      case (mode)
         0:       return sva_pkg::comp_type'($urandom);
         1:       return sva_pkg::comp_type'($urandom_range(16) - 8);
         default: return ($urandom_range(3) == 0) ? sva_pkg::comp_type'(0)
                                                  : sva_pkg::comp_type'($urandom);
      endcase
   endfunction

   // Random pair: full-range, small, parallel or antiparallel, sparse
   function automatic sva_pkg::req_type random_pair();
      sva_pkg::req_type t;
      int mode, k;
      mode  = $urandom_range(9);
      t.a_x = pick_comp(mode % 3); t.a_y = pick_comp(mode % 3); t.a_z = pick_comp(mode % 3);
      t.b_x = pick_comp(mode % 3); t.b_y = pick_comp(mode % 3); t.b_z = pick_comp(mode % 3);
      if (mode == 9) begin
         // Multiple of the first vector, optionally nudged
         k = $urandom_range(6) - 3;
         t.a_x = sva_pkg::comp_type'($urandom_range(20000) - 10000);
         t.a_y = sva_pkg::comp_type'($urandom_range(20000) - 10000);
         t.a_z = sva_pkg::comp_type'($urandom_range(20000) - 10000);
         t.b_x = sva_pkg::comp_type'(int'(t.a_x) * k + $urandom_range(2) - 1);
         t.b_y = sva_pkg::comp_type'(int'(t.a_y) * k);
         t.b_z = sva_pkg::comp_type'(int'(t.a_z) * k);
      end else if (mode == 8 && $urandom_range(9) == 0) begin
         if ($urandom_range(1)) {t.a_x, t.a_y, t.a_z} = '0;
         else                   {t.b_x, t.b_y, t.b_z} = '0;
      end
      return t;
   endfunction

   task automatic wait_drained();
      while (board.pending_angles.size() != 0) @(posedge clock);
   endtask

   initial begin
      send_idle_pct = 12;
      recv_idle_pct = 46;
      hold_request  = 0;
      hold_len      = 0;
      quiet_cycles  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero vectors, extremes, axes, sign about Z
      send_pair(0, 0, 0, 5, 6, 7);
      send_pair(1, 2, 3, 0, 0, 0);
      send_pair(0, 0, 0, 0, 0, 0);
      send_pair(1, 0, 0, 0, 1, 0);
      send_pair(0, 1, 0, 1, 0, 0);
      send_pair(1, 0, 0, 0, 0, 1);
      send_pair(3, 4, 5, 3, 4, 5);
      send_pair(3, 4, 5, -3, -4, -5);
      send_pair(-32768, -32768, -32768, -32768, -32768, -32768);
      send_pair(-32768, -32768, -32768, 32767, 32767, 32767);
      send_pair(32767, 32767, 32767, 32767, 32767, 32767);
      send_pair(-32768, 0, 0, 0, -32768, 0);
      send_pair(-32768, 0, 0, 0, 32767, 0);
      send_pair(32767, -32768, 0, -32768, 32767, 0);
      send_pair(1, 0, 0, 1, 1, 0);
      send_pair(1, 0, 0, 1, -1, 0);
      send_pair(1, 0, 0, -1, 1, 0);
      send_pair(1, 0, 0, -1, -1, 0);
      send_pair(32767, 0, 0, 32767, 1, 0);
      send_pair(32767, 0, 0, -32767, -1, 0);
      send_pair(1, 1, 1, -1, -1, 2);
      send_pair(-1, -1, -1, 1, 1, 1);

      // Drain pause: sender waits for every response
      req_ch.valid <= 1'b0;
      wait_drained();

      for (int n = 0; n < RandomItems; n++) begin
         if (n == RandomItems / 3) begin
            send_idle_pct = 46;
            recv_idle_pct = 12;
         end
         if (n == (2 * RandomItems) / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (n == RandomItems / 6) begin
            // Long response stall while requests keep coming
            hold_len     = 400;
            hold_request = hold_request + 1;
         end
         send_vectors(random_pair());
      end
      req_ch.valid <= 1'b0;

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (board.mismatches == 0 && board.orphans == 0 && board.pending_angles.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
